@@ rtl/block_buffer_cache_policy_assert.svh @@
// Assertion macros used by the cache directory datapath.
`ifndef BLOCK_BUFFER_CACHE_POLICY_ASSERT_SVH
`define BLOCK_BUFFER_CACHE_POLICY_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define BBC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cache directory check failed");

// Check that cons holds in the cycle after ante.
`define BBC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cache directory check failed");

`endif

@@ rtl/bbc_pkg.sv @@
// Shared constants, codes and control types of the cache directory.
package bbc_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int ADDR_W  = 24;
    localparam int MODE_W  = 2;

    localparam logic [MODE_W-1:0] MODE_READ  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FLUSH = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NONE  = 2'd3;

    typedef struct packed {
        logic capture;
        logic lookup;
        logic update;
        logic flush_step;
    } cmd_t;

    typedef struct packed {
        logic flush_last;
    } status_t;

endpackage

@@ rtl/block_buffer_cache_policy.sv @@
// Top level of the fully associative write-back cache directory.
// Access: accepted at start && !busy; the result strobes on done after the lookup and update states,
// and the next request is taken in that same cycle; none is taken while one is still busy.
// Flush: sixteen results, one per entry, on consecutive cycles, registered from the flush state.
// Tag compare over all entries runs in the lookup state; update and result register in the update state that follows.
// Reset empties the directory at once through the valid bits; no clearing pass is needed.
module block_buffer_cache_policy (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [bbc_pkg::MODE_W-1:0]   mode,
    input  logic [bbc_pkg::ADDR_W-1:0]   block_address,
    output logic                         busy,
    output logic                         done,
    output logic [bbc_pkg::IDX_W-1:0]    entry_index,
    output logic                         hit,
    output logic                         fetch,
    output logic                         write_back,
    output logic [bbc_pkg::ADDR_W-1:0]   write_back_address,
    output logic                         last
);

    bbc_pkg::cmd_t    cmd;
    bbc_pkg::status_t status;

    bbc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .mode   (mode),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    bbc_dpath u_dpath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .mode               (mode),
        .block_address      (block_address),
        .status             (status),
        .done               (done),
        .entry_index        (entry_index),
        .hit                (hit),
        .fetch              (fetch),
        .write_back         (write_back),
        .write_back_address (write_back_address),
        .last               (last)
    );

endmodule

@@ rtl/bbc_ctrl.sv @@
// Sequencer for lookup, update and flush of the cache directory.
module bbc_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [bbc_pkg::MODE_W-1:0]   mode,
    input  bbc_pkg::status_t             status,
    output bbc_pkg::cmd_t                cmd,
    output logic                         busy
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_LOOKUP = 2'd1;
    localparam logic [1:0] S_UPDATE = 2'd2;
    localparam logic [1:0] S_FLUSH  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (mode == bbc_pkg::MODE_READ || mode == bbc_pkg::MODE_WRITE)
                    begin
                        state_next = S_LOOKUP;
                    end
                    else if (mode == bbc_pkg::MODE_FLUSH)
                    begin
                        state_next = S_FLUSH;
                    end
                end
            end
            S_LOOKUP:
            begin
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                state_next = S_IDLE;
            end
            S_FLUSH:
            begin
                if (status.flush_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy           = (state_reg != S_IDLE);
    assign cmd.capture    = start && (state_reg == S_IDLE);
    assign cmd.lookup     = (state_reg == S_LOOKUP);
    assign cmd.update     = (state_reg == S_UPDATE);
    assign cmd.flush_step = (state_reg == S_FLUSH);

endmodule

@@ rtl/bbc_dpath.sv @@
// Tag, valid and dirty storage, tag compare, victim pointer and result register.
`include "block_buffer_cache_policy_assert.svh"

module bbc_dpath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  bbc_pkg::cmd_t                cmd,
    input  logic [bbc_pkg::MODE_W-1:0]   mode,
    input  logic [bbc_pkg::ADDR_W-1:0]   block_address,
    output bbc_pkg::status_t             status,
    output logic                         done,
    output logic [bbc_pkg::IDX_W-1:0]    entry_index,
    output logic                         hit,
    output logic                         fetch,
    output logic                         write_back,
    output logic [bbc_pkg::ADDR_W-1:0]   write_back_address,
    output logic                         last
);

    localparam int N  = bbc_pkg::ENTRIES;
    localparam int IW = bbc_pkg::IDX_W;
    localparam int AW = bbc_pkg::ADDR_W;

    logic [AW-1:0] tag_reg [N];
    logic [N-1:0]  valid_reg;
    logic [N-1:0]  dirty_reg;
    logic [IW-1:0] rr_reg;
    logic [IW-1:0] flush_idx_reg;

    logic [AW-1:0] addr_reg;
    logic          write_reg;

    logic [IW-1:0] sel_idx_reg;
    logic          hit_reg;
    logic          fetch_reg;
    logic          replace_reg;

    logic          done_reg;
    logic [IW-1:0] entry_reg;
    logic          hit_out_reg;
    logic          fetch_out_reg;
    logic          wb_reg;
    logic [AW-1:0] wba_reg;
    logic          last_reg;

    logic [N-1:0]  match;
    logic          hit_any;
    logic [IW-1:0] hit_idx;
    logic          free_any;
    logic [IW-1:0] free_idx;
    logic [IW-1:0] rd_idx;
    logic          rd_wb;
    logic [AW-1:0] rd_wba;

    // Valid entries always form a prefix, so the first match lies before the first free slot.
    always_comb
    begin
        hit_any  = 1'b0;
        hit_idx  = '0;
        free_any = 1'b0;
        free_idx = '0;
        for (int i = N - 1; i >= 0; i--)
        begin
            match[i] = valid_reg[i] && (tag_reg[i] == addr_reg);
            if (match[i])
            begin
                hit_any = 1'b1;
                hit_idx = IW'(i);
            end
            if (!valid_reg[i])
            begin
                free_any = 1'b1;
                free_idx = IW'(i);
            end
        end
    end

    assign rd_idx = cmd.flush_step ? flush_idx_reg : sel_idx_reg;
    assign rd_wb  = valid_reg[rd_idx] && dirty_reg[rd_idx];
    assign rd_wba = rd_wb ? tag_reg[rd_idx] : '0;

    assign status.flush_last = (flush_idx_reg == IW'(N - 1));

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            addr_reg  <= block_address;
            write_reg <= (mode == bbc_pkg::MODE_WRITE);
        end
        if (cmd.lookup)
        begin
            hit_reg     <= hit_any;
            fetch_reg   <= !hit_any;
            replace_reg <= !hit_any && !free_any;
            if (hit_any)
            begin
                sel_idx_reg <= hit_idx;
            end
            else if (free_any)
            begin
                sel_idx_reg <= free_idx;
            end
            else
            begin
                sel_idx_reg <= rr_reg;
            end
        end
        if (cmd.update && fetch_reg)
        begin
            tag_reg[sel_idx_reg] <= addr_reg;
        end
    end

    // Loads go round robin once full, so the oldest loaded entry is always the next slot in turn.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            dirty_reg     <= '0;
            rr_reg        <= '0;
            flush_idx_reg <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.update || cmd.flush_step;
            if (cmd.update)
            begin
                if (fetch_reg)
                begin
                    valid_reg[sel_idx_reg] <= 1'b1;
                    dirty_reg[sel_idx_reg] <= write_reg;
                end
                else
                begin
                    dirty_reg[sel_idx_reg] <= dirty_reg[sel_idx_reg] | write_reg;
                end
                if (replace_reg)
                begin
                    rr_reg <= (rr_reg == IW'(N - 1)) ? '0 : rr_reg + 1'b1;
                end
            end
            if (cmd.capture)
            begin
                flush_idx_reg <= '0;
            end
            else if (cmd.flush_step)
            begin
                flush_idx_reg <= flush_idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            entry_reg     <= sel_idx_reg;
            hit_out_reg   <= hit_reg;
            fetch_out_reg <= fetch_reg;
            wb_reg        <= rd_wb;
            wba_reg       <= rd_wba;
            last_reg      <= 1'b1;
        end
        else if (cmd.flush_step)
        begin
            entry_reg     <= flush_idx_reg;
            hit_out_reg   <= 1'b0;
            fetch_out_reg <= 1'b0;
            wb_reg        <= rd_wb;
            wba_reg       <= rd_wba;
            last_reg      <= status.flush_last;
        end
    end

    assign done               = done_reg;
    assign entry_index        = entry_reg;
    assign hit                = hit_out_reg;
    assign fetch              = fetch_out_reg;
    assign write_back         = wb_reg;
    assign write_back_address = wba_reg;
    assign last               = last_reg;

    `BBC_ASSERT_SAME(a_dirty_implies_valid, 1'b1, (dirty_reg & ~valid_reg) == '0)
    `BBC_ASSERT_SAME(a_victim_only_when_full, rr_reg != '0, &valid_reg)
    `BBC_ASSERT_NEXT(a_fill_sets_valid, cmd.update && fetch_reg, valid_reg[$past(sel_idx_reg)])

endmodule
